>>> rtl/dhfk_pkg.sv
// Shared constants, types and helpers of the six-joint kinematics pipeline.
`default_nettype none

package dhfk_pkg;

   // Joint registers and item layout
   localparam int JOINT_MAX    = 6;
   localparam int ANGLE_W      = 16;
   localparam int DH_W         = 64;
   localparam int LEN_W        = 24;
   localparam int DH_D_LSB     = 0;
   localparam int DH_A_LSB     = 24;
   localparam int DH_ALPHA_LSB = 48;
   localparam int CSR_INDEX_W  = 3;
   localparam int POS_W        = 32;
   localparam int ROT_W        = 18;
   localparam int REQ_DATA_W   = 96;
   localparam int RSP_DATA_W   = 264;

   // Register index of joint 0; joint j sits at this index plus j
   localparam int CSR_JOINT0_DH = 0;

   typedef logic [DH_W-1:0] dh_word_type;

   localparam dh_word_type DH_RESET [JOINT_MAX] = '{
      64'd4611686018427433779,
      64'd9223372586610602803,
      64'd13835058055282176819,
      64'd4611686018427419361,
      64'd13835058055282163712,
      64'd7209
   };

   // Quarter-turn sine polynomial, Q30 coefficients
   localparam int QTR_W = 15;
   localparam int SN_W  = 31;
   localparam logic [SN_W-1:0] SINE_C1 = 31'd1686629713;
   localparam logic [SN_W-1:0] SINE_C3 = 31'd693598669;
   localparam logic [SN_W-1:0] SINE_C5 = 31'd85569305;
   localparam logic [SN_W-1:0] SINE_C7 = 31'd5026995;
   localparam logic [SN_W-1:0] SINE_C9 = 31'd172272;
   localparam logic [QTR_W-1:0] QUARTER_TURN = 15'd16384;
   localparam logic [ANGLE_W-1:0] COS_OFFSET = 16'd16384;

   // One Horner step: c - (z * p) >> 30, never negative for z up to 1.0
   function automatic logic [SN_W-1:0] horner_step(input logic [SN_W-1:0] c,
                                                    input logic [SN_W-1:0] z,
                                                    input logic [SN_W-1:0] p);
      logic [2*SN_W-1:0] prod;
      prod = {{SN_W{1'b0}}, z} * {{SN_W{1'b0}}, p};
      return c - prod[2*SN_W-2:30];
   endfunction

endpackage

`default_nettype wire

>>> rtl/dh_forward_kinematics_six_joint.sv
// Pipelined six-joint Denavit-Hartenberg forward kinematics, top level.
//
// Request channel (req_): one transfer carries six 16-bit binary joint
// angles. Response channel (rsp_): one transfer per request with the
// end-effector position (Q16.16, saturated) and the 3x3 rotation (Q1.16).
// Config channel (csr_): csr_index selects joint register 0..5 (d, a, alpha
// packed); other indexes are dropped. csr_ready is always high. Write only
// while no request is in flight.
// Stages from request to response: seven of sine polynomial, one for the
// link transform, two per joint for the chained matrix product and one
// output register.
// Throughput: one transfer per cycle unless a stall holds the output; joint j
// enters its own trig pipeline delayed so its transform meets the frame of joint j-1.
// Reset clears all valid bits and loads the default arm geometry.
// A stall on rsp_tready freezes the whole pipeline and holds req_tready low
// only while the output register is full and not taken.
`default_nettype none

module dh_forward_kinematics_six_joint #(
   parameter int JOINT_COUNT = 6,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // joint0_angle [15:0], joint1_angle .. joint5_angle, 16 bits each upward
   input  wire logic [95:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x [31:0], pos_y [63:32], pos_z [95:64], then rot_r00, r01, r02,
   // r10, r11, r12, r20, r21, r22 at 18 bits each from bit 96, zero above 257
   output logic [263:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);

   localparam int RW  = FRAC_BITS + 3;
   localparam int PW  = FRAC_BITS + 13;
   localparam int LAT = 8 + 2 * JOINT_COUNT;
   localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
   localparam logic signed [63:0] POS_MIN = -64'sd2147483648;
   localparam logic signed [63:0] ROT_MAX = 64'sd131071;
   localparam logic signed [63:0] ROT_MIN = -64'sd131072;

   logic pipe_advance;
   logic vld_ff [LAT];
   logic rsp_valid_ff;
   logic [dhfk_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [dhfk_pkg::RSP_DATA_W-1:0] rsp_data_in;

   logic signed [RW-1:0] chain_r [JOINT_COUNT+1][3][3];
   logic signed [PW-1:0] chain_p [JOINT_COUNT+1][3];

   logic signed [63:0] pos_w [3];
   logic signed [63:0] rot_w [3][3];

   // The whole pipeline moves when the output register is free or taken
   assign pipe_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready   = pipe_advance;
   assign csr_ready    = 1'b1;

   // Start from the identity frame at the base
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            chain_r[0][r][c] = (r == c) ? RW'(ONE) : '0;
         end
         chain_p[0][r] = '0;
      end
   end

   for (genvar j = 0; j < JOINT_COUNT; j++) begin : g_joint
      dhfk_pkg::dh_word_type dh_ff;
      logic [15:0]           angle_j;
      dhfk_pkg::dh_word_type dh_j;

      // Joint register, written through the config channel
      always_ff @(posedge clock) begin
         if (reset) begin
            dh_ff <= dhfk_pkg::DH_RESET[j];
         end else if (csr_valid && csr_ready &&
                      csr_index == dhfk_pkg::CSR_INDEX_W'(dhfk_pkg::CSR_JOINT0_DH + j)) begin
            dh_ff <= csr_data;
         end
      end

      // Delay this joint's inputs so its transform meets the previous frame
      if (j == 0) begin : g_direct
         assign angle_j = req_tdata[0 +: 16];
         assign dh_j    = dh_ff;
      end else begin : g_delay
         logic [15:0]           ang_dly_ff [2*j];
         dhfk_pkg::dh_word_type dh_dly_ff  [2*j];
         always_ff @(posedge clock) begin
            if (pipe_advance) begin
               ang_dly_ff[0] <= req_tdata[16*j +: 16];
               dh_dly_ff[0]  <= dh_ff;
               for (int i = 1; i < 2*j; i++) begin
                  ang_dly_ff[i] <= ang_dly_ff[i-1];
                  dh_dly_ff[i]  <= dh_dly_ff[i-1];
               end
            end
         end
         assign angle_j = ang_dly_ff[2*j-1];
         assign dh_j    = dh_dly_ff[2*j-1];
      end

      dhfk_joint #(.FRAC_BITS(FRAC_BITS)) u_joint (
         .clock  (clock),
         .enable (pipe_advance),
         .angle  (angle_j),
         .dh     (dh_j),
         .r_in   (chain_r[j]),
         .p_in   (chain_p[j]),
         .r_out  (chain_r[j+1]),
         .p_out  (chain_p[j+1])
      );
   end

   // Saturate position, clamp rotation and pack the response
   always_comb begin
      rsp_data_in = '0;
      for (int r = 0; r < 3; r++) begin
         pos_w[r] = 64'(chain_p[JOINT_COUNT][r]);
         if (pos_w[r] > POS_MAX) pos_w[r] = POS_MAX;
         if (pos_w[r] < POS_MIN) pos_w[r] = POS_MIN;
         rsp_data_in[32*r +: 32] = pos_w[r][31:0];
         for (int c = 0; c < 3; c++) begin
            rot_w[r][c] = 64'(chain_r[JOINT_COUNT][r][c]);
            if (rot_w[r][c] > ONE)     rot_w[r][c] = ONE;
            if (rot_w[r][c] < -ONE)    rot_w[r][c] = -ONE;
            if (rot_w[r][c] > ROT_MAX) rot_w[r][c] = ROT_MAX;
            if (rot_w[r][c] < ROT_MIN) rot_w[r][c] = ROT_MIN;
            rsp_data_in[96 + 18*(3*r + c) +: 18] = rot_w[r][c][17:0];
         end
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_advance) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/dhfk_sine.sv
// Seven-stage pipelined sine of a 16-bit binary angle.
`default_nettype none

module dhfk_sine #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic [15:0]                angle,
   output logic signed [FRAC_BITS+1:0]     sine
);

   localparam int TW  = FRAC_BITS + 2;
   localparam int RND = 30 - FRAC_BITS;
   localparam logic [32:0] HALF = 33'd1 << (RND - 1);
   localparam logic [32:0] ONE  = 33'd1 << FRAC_BITS;

   logic [dhfk_pkg::QTR_W-1:0] fold_in;
   logic [29:0]                sq_in;
   logic [dhfk_pkg::SN_W-1:0]  z_in;
   logic [45:0]                s_prod_in;
   logic [32:0]                rnd_in;
   logic [32:0]                cap_in;
   logic signed [TW-1:0]       sine_in;

   logic [dhfk_pkg::QTR_W-1:0] r_ff   [5];
   logic [dhfk_pkg::SN_W-1:0]  z_ff   [4];
   logic [dhfk_pkg::SN_W-1:0]  p_ff   [4];
   logic                       neg_ff [6];
   logic [31:0]                s_ff;
   logic signed [TW-1:0]       sine_ff;

   // Fold to the first quarter, square, multiply by the folded angle, then round, cap and sign the result
   always_comb begin
      fold_in = angle[14] ? (dhfk_pkg::QUARTER_TURN - {1'b0, angle[13:0]})
                          : {1'b0, angle[13:0]};
      sq_in = 30'(fold_in) * 30'(fold_in);
      z_in = {sq_in[28:0], 2'b00};
      s_prod_in = 46'(r_ff[4]) * 46'(p_ff[3]);
      rnd_in = ({1'b0, s_ff} + HALF) >> RND;
      cap_in = (rnd_in > ONE) ? ONE : rnd_in;
      sine_in = neg_ff[5] ? -TW'(cap_in) : TW'(cap_in);
   end

   // Advance every stage together
   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0]   <= fold_in;
         z_ff[0]   <= z_in;
         neg_ff[0] <= angle[15];
         for (int i = 1; i < 5; i++) r_ff[i] <= r_ff[i-1];
         for (int i = 1; i < 4; i++) z_ff[i] <= z_ff[i-1];
         for (int i = 1; i < 6; i++) neg_ff[i] <= neg_ff[i-1];
         p_ff[0] <= dhfk_pkg::horner_step(dhfk_pkg::SINE_C7, z_ff[0], dhfk_pkg::SINE_C9);
         p_ff[1] <= dhfk_pkg::horner_step(dhfk_pkg::SINE_C5, z_ff[1], p_ff[0]);
         p_ff[2] <= dhfk_pkg::horner_step(dhfk_pkg::SINE_C3, z_ff[2], p_ff[1]);
         p_ff[3] <= dhfk_pkg::horner_step(dhfk_pkg::SINE_C1, z_ff[3], p_ff[2]);
         s_ff    <= s_prod_in[45:14];
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

>>> rtl/dhfk_joint.sv
// One joint: trig, link transform and the chained matrix product, ten stages.
`default_nettype none

module dhfk_joint #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic [15:0]                       angle,
   input  wire logic [63:0]                       dh,
   input  wire logic signed [FRAC_BITS+2:0]       r_in  [3][3],
   input  wire logic signed [FRAC_BITS+12:0]      p_in  [3],
   output logic signed [FRAC_BITS+2:0]            r_out [3][3],
   output logic signed [FRAC_BITS+12:0]           p_out [3]
);

   localparam int LEN_UP   = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
   localparam int LEN_DOWN = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
   localparam int LW  = dhfk_pkg::LEN_W + LEN_UP;
   localparam int TW  = FRAC_BITS + 2;
   localparam int TPW = LW + 1;
   localparam int RW  = FRAC_BITS + 3;
   localparam int PW  = FRAC_BITS + 13;
   localparam int SRW = RW + TW + 2;
   localparam int SPW = RW + TPW + 2;
   localparam int SIN_LAT = 7;

   localparam logic signed [2*TW-1:0]  HALF_T = (2*TW)'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [LW+TW-1:0] HALF_L = (LW+TW)'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SRW-1:0]   HALF_R = SRW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SPW-1:0]   HALF_P = SPW'(1) <<< (FRAC_BITS - 1);

   logic signed [TW-1:0]  st, ct, sa, ca;
   logic signed [LW-1:0]  d_len_in, a_len_in;
   logic signed [LW-1:0]  d_ff [SIN_LAT];
   logic signed [LW-1:0]  a_ff [SIN_LAT];

   logic signed [TW-1:0]     tr_in [3][3];
   logic signed [TPW-1:0]    tp_in [3];
   logic signed [TW-1:0]     tr_ff [3][3];
   logic signed [TPW-1:0]    tp_ff [3];

   logic signed [RW+TW-1:0]  pr_in [3][3][3];
   logic signed [RW+TPW-1:0] pp_in [3][3];
   logic signed [RW+TW-1:0]  pr_ff [3][3][3];
   logic signed [RW+TPW-1:0] pp_ff [3][3];
   logic signed [PW-1:0]     pd_ff [3];

   logic signed [SRW-1:0]    sr_w [3][3];
   logic signed [SPW-1:0]    sp_w [3];
   logic signed [RW-1:0]     r_out_in [3][3];
   logic signed [PW-1:0]     p_out_in [3];
   logic signed [RW-1:0]     r_out_ff [3][3];
   logic signed [PW-1:0]     p_out_ff [3];

   function automatic logic signed [TW-1:0] mul_trig(input logic signed [TW-1:0] x,
                                                     input logic signed [TW-1:0] y);
      logic signed [2*TW-1:0] prod;
      prod = (2*TW)'(x) * (2*TW)'(y) + HALF_T;
      return TW'(prod >>> FRAC_BITS);
   endfunction

   function automatic logic signed [TPW-1:0] mul_len(input logic signed [LW-1:0] x,
                                                     input logic signed [TW-1:0] y);
      logic signed [LW+TW-1:0] prod;
      prod = (LW+TW)'(x) * (LW+TW)'(y) + HALF_L;
      return TPW'(prod >>> FRAC_BITS);
   endfunction

   // Joint angle and twist, sine and cosine
   dhfk_sine #(.FRAC_BITS(FRAC_BITS)) u_sin_theta (
      .clock(clock), .enable(enable), .angle(angle), .sine(st));
   dhfk_sine #(.FRAC_BITS(FRAC_BITS)) u_cos_theta (
      .clock(clock), .enable(enable), .angle(angle + dhfk_pkg::COS_OFFSET), .sine(ct));
   dhfk_sine #(.FRAC_BITS(FRAC_BITS)) u_sin_alpha (
      .clock(clock), .enable(enable),
      .angle(dh[dhfk_pkg::DH_ALPHA_LSB +: 16]), .sine(sa));
   dhfk_sine #(.FRAC_BITS(FRAC_BITS)) u_cos_alpha (
      .clock(clock), .enable(enable),
      .angle(dh[dhfk_pkg::DH_ALPHA_LSB +: 16] + dhfk_pkg::COS_OFFSET), .sine(ca));

   // Scale link offset and length to the internal fraction
   if (FRAC_BITS >= 16) begin : g_len_up
      assign d_len_in = LW'($signed(dh[dhfk_pkg::DH_D_LSB +: dhfk_pkg::LEN_W])) <<< LEN_UP;
      assign a_len_in = LW'($signed(dh[dhfk_pkg::DH_A_LSB +: dhfk_pkg::LEN_W])) <<< LEN_UP;
   end else begin : g_len_down
      localparam logic signed [LW:0] HALF_D = (LW+1)'(1) <<< (LEN_DOWN - 1);
      logic signed [LW:0] d_sum, a_sum;
      assign d_sum = (LW+1)'($signed(dh[dhfk_pkg::DH_D_LSB +: dhfk_pkg::LEN_W])) + HALF_D;
      assign a_sum = (LW+1)'($signed(dh[dhfk_pkg::DH_A_LSB +: dhfk_pkg::LEN_W])) + HALF_D;
      assign d_len_in = LW'(d_sum >>> LEN_DOWN);
      assign a_len_in = LW'(a_sum >>> LEN_DOWN);
   end

   // Link transform from the trig values
   always_comb begin
      tr_in[0][0] = ct;
      tr_in[0][1] = -mul_trig(st, ca);
      tr_in[0][2] = mul_trig(st, sa);
      tr_in[1][0] = st;
      tr_in[1][1] = mul_trig(ct, ca);
      tr_in[1][2] = -mul_trig(ct, sa);
      tr_in[2][0] = '0;
      tr_in[2][1] = sa;
      tr_in[2][2] = ca;
      tp_in[0] = mul_len(a_ff[SIN_LAT-1], ct);
      tp_in[1] = mul_len(a_ff[SIN_LAT-1], st);
      tp_in[2] = TPW'(d_ff[SIN_LAT-1]);
   end

   // Products of the incoming frame with the link transform
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               pr_in[r][c][k] = (RW+TW)'(r_in[r][k]) * (RW+TW)'(tr_ff[k][c]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            pp_in[r][k] = (RW+TPW)'(r_in[r][k]) * (RW+TPW)'(tp_ff[k]);
         end
      end
   end

   // Sum, round and add the carried position
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sr_w[r][c] = SRW'(pr_ff[r][c][0]) + SRW'(pr_ff[r][c][1])
                       + SRW'(pr_ff[r][c][2]) + HALF_R;
            r_out_in[r][c] = RW'(sr_w[r][c] >>> FRAC_BITS);
         end
         sp_w[r] = SPW'(pp_ff[r][0]) + SPW'(pp_ff[r][1]) + SPW'(pp_ff[r][2]) + HALF_P;
         p_out_in[r] = PW'(sp_w[r] >>> FRAC_BITS) + pd_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff[0] <= d_len_in;
         a_ff[0] <= a_len_in;
         for (int i = 1; i < SIN_LAT; i++) begin
            d_ff[i] <= d_ff[i-1];
            a_ff[i] <= a_ff[i-1];
         end
         tr_ff    <= tr_in;
         tp_ff    <= tp_in;
         pr_ff    <= pr_in;
         pp_ff    <= pp_in;
         pd_ff    <= p_in;
         r_out_ff <= r_out_in;
         p_out_ff <= p_out_in;
      end
   end

   assign r_out = r_out_ff;
   assign p_out = p_out_ff;

endmodule

`default_nettype wire

>>> rtl/dhfk_checker.sv
// Port-level checks for the kinematics pipeline and their binding.
`default_nettype none

module dhfk_checker #(
   parameter int FRAC_BITS = 16
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [263:0] rsp_tdata
);

   localparam int ROT_LIM = ((1 << FRAC_BITS) > 131071) ? 131071 : (1 << FRAC_BITS);

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // An empty output register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Rotation entries r00 and r22 stay within one or the 18-bit limit, whichever is smaller
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[113:96]) <= ROT_LIM &&
                     $signed(rsp_tdata[113:96]) >= -ROT_LIM &&
                     $signed(rsp_tdata[257:240]) <= ROT_LIM &&
                     $signed(rsp_tdata[257:240]) >= -ROT_LIM)
      else $error("rotation entry out of range");

endmodule

bind dh_forward_kinematics_six_joint dhfk_checker #(.FRAC_BITS(FRAC_BITS)) u_dhfk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
